// ===== hdl/ps2mct_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types, constants and a helper function for the PS/2 mouse packet
// decoder and cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_W          = 13;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned DELTA_W        = 10;

  // Header bit positions.
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_SYNC   = 3;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;
  localparam int unsigned HDR_XOVF   = 6;
  localparam int unsigned HDR_YOVF   = 7;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  // Register index, taken from paddr bit 2.
  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_index_t;

  // Position of the next byte inside a three-byte packet.
  typedef enum logic [1:0] {
    SLOT_HEADER = 2'd0,
    SLOT_XDELTA = 2'd1,
    SLOT_YDELTA = 2'd2
  } byte_slot_t;

  typedef logic signed [DELTA_W-1:0] delta_t;

  // Completed packet handed from the framer to the tracker.
  typedef struct packed {
    logic              complete;
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] x_byte;
    logic [BYTE_W-1:0] y_byte;
  } packet_t;

  // 9-bit signed delta, extended by 255 in the sign direction on overflow.
  function automatic delta_t delta9(input logic [BYTE_W-1:0] mag, input logic neg,
                                    input logic ovf);
    delta_t d;
    d = $signed({1'b0, neg, mag});
    d = neg ? d - delta_t'(512) : d;
    if (ovf) begin
      d = neg ? d - delta_t'(255) : d + delta_t'(255);
    end
    return d;
  endfunction

endpackage

// ===== hdl/ps2_mouse_packet_cursor_tracker_core.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// PS/2 mouse byte stream in, clamped cursor position and buttons out.
// ----------------------------------------------------------------------------
// Raw mouse bytes enter on the s_axis channel, one byte per item. The first
// byte after reset is dropped; after that, bytes are framed into three-byte
// packets, a header being recognized by its sync bit. The third byte of each
// packet produces one item on m_axis with the new cursor position and the
// three button states; header and X bytes produce nothing.
// An accepted Y byte passes through the input register, then through the add
// and clamp into the output register. One byte is taken every cycle, limited
// only by the output register when a result is waiting.
// Reset clears the packet framer, sets the cursor to the top left corner and
// loads the screen size registers with 1024 by 768. While m_axis_tready is
// low and a result waits, the byte in the input register holds and
// s_axis_tready drops; nothing is lost. The APB port sets the screen width
// (address 0) and height (address 4); write them only while the stream is
// idle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF,
  localparam int unsigned TDATA_W   = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ps2mct_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ps2mct_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ps2mct_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  // Mouse bytes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ps2mct_pkg::BYTE_W-1:0]     s_axis_tdata,   // data_byte
  // Cursor results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cursor_x, cursor_y, left_pressed, middle_pressed, right_pressed, zero fill
  output logic [TDATA_W-1:0]                m_axis_tdata
);

  logic [ps2mct_pkg::CFG_W-1:0]  screen_width;
  logic [ps2mct_pkg::CFG_W-1:0]  screen_height;
  logic                          in_valid;
  logic [ps2mct_pkg::BYTE_W-1:0] in_byte;
  logic                          advance;
  ps2mct_pkg::packet_t           pkt;
  ps2mct_pkg::reg_index_t        reg_sel;
  logic [COORD_BITS-1:0]         cursor_x;
  logic [COORD_BITS-1:0]         cursor_y;
  logic                          left_pressed;
  logic                          middle_pressed;
  logic                          right_pressed;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = ps2mct_pkg::reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mct_pkg::SCREEN_WIDTH_RST;
      screen_height <= ps2mct_pkg::SCREEN_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        ps2mct_pkg::REG_SCREEN_WIDTH:  screen_width  <= pwdata[ps2mct_pkg::CFG_W-1:0];
        ps2mct_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[ps2mct_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ps2mct_pkg::REG_SCREEN_WIDTH:  prdata = ps2mct_pkg::APB_DATA_W'(screen_width);
      ps2mct_pkg::REG_SCREEN_HEIGHT: prdata = ps2mct_pkg::APB_DATA_W'(screen_height);
      default:                       prdata = '0;
    endcase
  end

  // Input register; the byte moves on whenever the output register can take
  // a result this cycle.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  ps2mct_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .pkt       (pkt)
  );

  ps2mct_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .pkt            (pkt),
    .screen_width   (screen_width),
    .screen_height  (screen_height),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .left_pressed   (left_pressed),
    .middle_pressed (middle_pressed),
    .right_pressed  (right_pressed)
  );

  assign m_axis_tdata = TDATA_W'({right_pressed, middle_pressed, left_pressed,
                                  cursor_y, cursor_x});

endmodule

// ===== hdl/ps2mct_framer.sv =====
// ----------------------------------------------------------------------------
// ps2mct_framer
// Groups raw mouse bytes into header / X / Y packets, dropping the first
// byte after reset and resynchronizing on the header sync bit.
// ----------------------------------------------------------------------------
module ps2mct_framer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [ps2mct_pkg::BYTE_W-1:0] data_byte,
  output ps2mct_pkg::packet_t          pkt
);

  logic                          first_pending;
  logic                          first_pending_next;
  ps2mct_pkg::byte_slot_t        byte_index;
  ps2mct_pkg::byte_slot_t        byte_index_next;
  logic [ps2mct_pkg::BYTE_W-1:0] header_byte;
  logic [ps2mct_pkg::BYTE_W-1:0] header_byte_next;
  logic [ps2mct_pkg::BYTE_W-1:0] x_delta_byte;
  logic [ps2mct_pkg::BYTE_W-1:0] x_delta_byte_next;

  always_comb begin
    first_pending_next = first_pending;
    byte_index_next    = byte_index;
    header_byte_next   = header_byte;
    x_delta_byte_next  = x_delta_byte;
    if (step) begin
      if (first_pending) begin
        first_pending_next = 1'b0;
      end else begin
        unique case (byte_index)
          ps2mct_pkg::SLOT_XDELTA: begin
            x_delta_byte_next = data_byte;
            byte_index_next   = ps2mct_pkg::SLOT_YDELTA;
          end
          ps2mct_pkg::SLOT_YDELTA: begin
            byte_index_next = ps2mct_pkg::SLOT_HEADER;
          end
          default: begin
            // A header byte must carry the sync bit, otherwise it is skipped.
            if (data_byte[ps2mct_pkg::HDR_SYNC]) begin
              header_byte_next = data_byte;
              byte_index_next  = ps2mct_pkg::SLOT_XDELTA;
            end else begin
              byte_index_next = ps2mct_pkg::SLOT_HEADER;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    pkt.complete = step && !first_pending && (byte_index == ps2mct_pkg::SLOT_YDELTA);
    pkt.header   = header_byte;
    pkt.x_byte   = x_delta_byte;
    pkt.y_byte   = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      byte_index    <= ps2mct_pkg::SLOT_HEADER;
      header_byte   <= '0;
      x_delta_byte  <= '0;
    end else begin
      first_pending <= first_pending_next;
      byte_index    <= byte_index_next;
      header_byte   <= header_byte_next;
      x_delta_byte  <= x_delta_byte_next;
    end
  end

endmodule

// ===== hdl/ps2mct_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2mct_tracker
// Applies packet deltas to the cursor position, clamps it to the screen and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module ps2mct_tracker #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ps2mct_pkg::packet_t          pkt,
  input  logic [ps2mct_pkg::CFG_W-1:0] screen_width,
  input  logic [ps2mct_pkg::CFG_W-1:0] screen_height,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [COORD_BITS-1:0]        cursor_x,
  output logic [COORD_BITS-1:0]        cursor_y,
  output logic                         left_pressed,
  output logic                         middle_pressed,
  output logic                         right_pressed
);

  // Sum width: position plus a delta of up to +-511, with a sign bit.
  localparam int unsigned SW = COORD_BITS + 3;
  localparam int unsigned LW = ((COORD_BITS > ps2mct_pkg::CFG_W) ?
                                COORD_BITS : ps2mct_pkg::CFG_W) + 1;

  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  ps2mct_pkg::delta_t    dx;
  ps2mct_pkg::delta_t    dy;
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic signed [SW-1:0] v, input logic [ps2mct_pkg::CFG_W-1:0] size);
    logic [ps2mct_pkg::CFG_W-1:0] lim_raw;
    logic [LW-1:0]                lim_wide;
    logic [LW-1:0]                cmax;
    logic [COORD_BITS-1:0]        lim;
    logic [COORD_BITS-1:0]        res;
    lim_raw  = (size == '0) ? '0 : size - 1'b1;
    lim_wide = LW'(lim_raw);
    cmax     = LW'({COORD_BITS{1'b1}});
    lim      = (lim_wide > cmax) ? cmax[COORD_BITS-1:0] : lim_wide[COORD_BITS-1:0];
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({3'b000, lim})) begin
      res = lim;
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  always_comb begin
    dx = ps2mct_pkg::delta9(pkt.x_byte, pkt.header[ps2mct_pkg::HDR_XSIGN],
                            pkt.header[ps2mct_pkg::HDR_XOVF]);
    dy = ps2mct_pkg::delta9(pkt.y_byte, pkt.header[ps2mct_pkg::HDR_YSIGN],
                            pkt.header[ps2mct_pkg::HDR_YOVF]);
    sum_x = $signed({3'b000, pos_x}) + SW'(dx);
    // Mouse Y grows upward, screen Y grows downward.
    sum_y = $signed({3'b000, pos_y}) - SW'(dy);
    pos_x_next = clamp_axis(sum_x, screen_width);
    pos_y_next = clamp_axis(sum_y, screen_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
    end else if (pkt.complete) begin
      out_valid <= 1'b1;
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.complete) begin
      cursor_x       <= pos_x_next;
      cursor_y       <= pos_y_next;
      left_pressed   <= pkt.header[ps2mct_pkg::HDR_LEFT];
      middle_pressed <= pkt.header[ps2mct_pkg::HDR_MIDDLE];
      right_pressed  <= pkt.header[ps2mct_pkg::HDR_RIGHT];
    end
  end

endmodule

// ===== hdl/ps2mct_checker.sv =====
// ----------------------------------------------------------------------------
// ps2mct_checker
// Port-level checks for the cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ps2mct_checker #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF,
  localparam int unsigned TDATA_W   = ((2 * COORD_BITS + 3 + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [TDATA_W-1:0]            m_axis_tdata
);

  // A waiting result stays and keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // With no result pending the block must take input.
  assert property (@(posedge clk) disable iff (rst) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A fresh result comes from a byte accepted through the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input byte");

endmodule

bind ps2_mouse_packet_cursor_tracker_core ps2mct_checker #(
  .COORD_BITS (COORD_BITS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/ps2mct_cursor_checker.sv =====
// ----------------------------------------------------------------------------
// ps2mct_cursor_checker
// Watches the byte stream, the cursor stream and the APB writes of the PS/2
// cursor tracker, predicts each cursor item and compares it field by field.
// ----------------------------------------------------------------------------
module ps2mct_cursor_checker
  import ps2mct_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned TDATA_W    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [TDATA_W-1:0]    m_axis_tdata,
  output int                    fails,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  middle;
    logic                  right;
  } cursor_t;

  cursor_t               expected_cursor[$];
  logic [CFG_W-1:0]      width_reg;
  logic [CFG_W-1:0]      height_reg;
  logic                  drop_next;
  byte_slot_t            slot;
  logic [BYTE_W-1:0]     hdr;
  logic [BYTE_W-1:0]     xbyte;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;

  initial begin
    fails = 0;
    outstanding = 0;
  end

  function automatic int signed_move(input logic [BYTE_W-1:0] mag, input logic neg,
                                     input logic ovf);
    int d;
    d = neg ? int'(mag) - 256 : int'(mag);
    if (ovf) begin
      d += neg ? -255 : 255;
    end
    return d;
  endfunction

  // A size of zero behaves as one; the limit never exceeds the coordinate range.
  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v,
                                                        input logic [CFG_W-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > (1 << COORD_BITS) - 1) begin
      lim = (1 << COORD_BITS) - 1;
    end
    if (v < 0) begin
      return '0;
    end
    if (v > lim) begin
      return COORD_BITS'(lim);
    end
    return COORD_BITS'(v);
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (fails < 40) begin
      $display("%0t ns cursor check: %s got %0d want %0d", $time, what, got, want);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    cursor_t got;
    cursor_t want;
    int dx;
    int dy;
    if (rst) begin
      expected_cursor.delete();
      width_reg  = SCREEN_WIDTH_RST;
      height_reg = SCREEN_HEIGHT_RST;
      drop_next  = 1'b1;
      slot       = SLOT_HEADER;
      hdr        = '0;
      xbyte      = '0;
      cur_x      = '0;
      cur_y      = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (int'(paddr >> 2) == int'(REG_SCREEN_WIDTH)) begin
          width_reg = pwdata[CFG_W-1:0];
        end else if (int'(paddr >> 2) == int'(REG_SCREEN_HEIGHT)) begin
          height_reg = pwdata[CFG_W-1:0];
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cursor.size() == 0) begin
          report("unexpected cursor item, tdata", int'(m_axis_tdata), 0);
        end else begin
          want = expected_cursor.pop_front();
          got.x      = m_axis_tdata[COORD_BITS-1:0];
          got.y      = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
          got.left   = m_axis_tdata[2*COORD_BITS];
          got.middle = m_axis_tdata[2*COORD_BITS+1];
          got.right  = m_axis_tdata[2*COORD_BITS+2];
          if (got.x != want.x) report("cursor_x", got.x, want.x);
          if (got.y != want.y) report("cursor_y", got.y, want.y);
          if (got.left != want.left) report("left_pressed", got.left, want.left);
          if (got.middle != want.middle) report("middle_pressed", got.middle, want.middle);
          if (got.right != want.right) report("right_pressed", got.right, want.right);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (drop_next) begin
          drop_next = 1'b0;
        end else begin
          case (slot)
            SLOT_XDELTA: begin
              xbyte = s_axis_tdata;
              slot  = SLOT_YDELTA;
            end
            SLOT_YDELTA: begin
              dx = signed_move(xbyte, hdr[HDR_XSIGN], hdr[HDR_XOVF]);
              dy = signed_move(s_axis_tdata, hdr[HDR_YSIGN], hdr[HDR_YOVF]);
              cur_x = clamp_coord(int'(cur_x) + dx, width_reg);
              cur_y = clamp_coord(int'(cur_y) - dy, height_reg);
              want.x      = cur_x;
              want.y      = cur_y;
              want.left   = hdr[HDR_LEFT];
              want.middle = hdr[HDR_MIDDLE];
              want.right  = hdr[HDR_RIGHT];
              expected_cursor.push_back(want);
              slot = SLOT_HEADER;
            end
            default: begin
              // Only a byte with the sync bit can open a packet.
              if (s_axis_tdata[HDR_SYNC]) begin
                hdr  = s_axis_tdata;
                slot = SLOT_XDELTA;
              end else begin
                slot = SLOT_HEADER;
              end
            end
          endcase
        end
      end
    end
    outstanding <= expected_cursor.size();
  end

endmodule

// ===== tb/tb_ps2_mouse_packet_cursor_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_cursor_tracker_core
// Drives mouse bytes and screen size writes into the cursor tracker.
// Directed packets hit the delta and clamp corners, then random packets and
// noise run under several screen sizes with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_cursor_tracker_core;
  import ps2mct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TDATA_W     = ((2 * COORD_BITS_DEF + 3 + 7) / 8) * 8;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PER_PHASE   = 140;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;  // data_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // cursor_x, cursor_y, left_pressed, middle_pressed, right_pressed, zero fill
  logic [TDATA_W-1:0]    m_axis_tdata;

  int fails;
  int outstanding;
  bit sender_steady;
  bit receiver_steady;
  bit hold_req;
  int drift;

  always #6 clk = ~clk;

  ps2_mouse_packet_cursor_tracker_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  ps2mct_cursor_checker #(.COORD_BITS(COORD_BITS_DEF), .TDATA_W(TDATA_W)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fails(fails), .outstanding(outstanding)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] x,
                             input logic [BYTE_W-1:0] y);
    send_byte(h);
    send_byte(x);
    send_byte(y);
  endtask

  function automatic logic [BYTE_W-1:0] random_header();
    logic [BYTE_W-1:0] h;
    h = BYTE_W'($urandom_range(0, 255));
    h[HDR_SYNC] = 1'b1;
    if ($urandom_range(0, 9) < 4) begin
      h[HDR_XOVF] = 1'b0;
      h[HDR_YOVF] = 1'b0;
    end
    // Drift pushes the cursor toward one corner so that both clamps are reached.
    if (drift != 0 && $urandom_range(0, 9) < 6) begin
      h[HDR_XSIGN] = (drift == 2);
      h[HDR_YSIGN] = (drift == 1);
    end
    return h;
  endfunction

  // Stop the stream and wait until every predicted item has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int sent;
    int r;
    int packets;
    sent = 0;
    packets = 0;
    while (sent < count) begin
      if (packets % 20 == 0) drift = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_packet(random_header(), BYTE_W'($urandom_range(0, 255)),
                    BYTE_W'($urandom_range(0, 255)));
        sent += 3;
        packets++;
      end else if (r < 93) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
        sent += 1;
      end else begin
        // A packet cut short; the next header lands in its Y slot.
        send_byte(random_header());
        send_byte(BYTE_W'($urandom_range(0, 255)));
        sent += 2;
      end
    end
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    receiver_steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) receiver_steady = ~receiver_steady;
      gap = pick_gap(receiver_steady);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    #10ms;
    $display("FAIL ps2_mouse_packet_cursor_tracker_core");
    $finish;
  end

  initial begin
    int unsigned widths[10];
    int unsigned heights[10];
    widths  = '{1, 0, 4096, 8191, 1, 4096, 640, 0, 2, 1024};
    heights = '{1, 0, 4096, 8191, 4096, 1, 480, 0, 3, 768};
    widths[7]  = $urandom();
    heights[7] = $urandom();

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sender_steady = 1'b0;
    hold_req      = 1'b0;
    drift         = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset screen size of 1024 by 768.
    send_byte(8'h08);                  // first byte after reset is dropped
    send_byte(8'h00);                  // no sync bit, ignored
    send_byte(8'hF7);                  // every bit but sync, ignored
    send_packet(8'h0F, 8'hFF, 8'h00);  // all buttons, x +255
    send_packet(8'h49, 8'hFF, 8'h00);  // x overflow, +510
    send_packet(8'h4A, 8'hFF, 8'h00);  // x clamps at width minus one
    send_packet(8'hAC, 8'h00, 8'h01);  // y sign and overflow, down 510
    send_packet(8'hA8, 8'h00, 8'h00);  // y clamps at height minus one
    send_packet(8'h58, 8'h00, 8'h00);  // x -511
    send_packet(8'h5F, 8'h00, 8'h00);  // x -511 again, down to one
    send_packet(8'h8D, 8'hFF, 8'hFF);  // y up 510 with x +255
    run_random(PER_PHASE);

    for (int p = 0; p < 10; p++) begin
      drain();
      apb_write(REG_SCREEN_WIDTH, widths[p]);
      apb_write(REG_SCREEN_HEIGHT, heights[p]);
      sender_steady = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        // Long receiver hold-off while the sender keeps offering packets.
        hold_req = 1'b1;
        sender_steady = 1'b1;
        run_random(90);
        sender_steady = 1'b0;
        run_random(PER_PHASE - 90);
      end else begin
        run_random(PER_PHASE);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("PASS ps2_mouse_packet_cursor_tracker_core");
    end else begin
      $display("FAIL ps2_mouse_packet_cursor_tracker_core");
    end
    $finish;
  end

endmodule

// ===== ps2_mouse_packet_cursor_tracker_core.f =====
hdl/ps2mct_pkg.sv
hdl/ps2mct_framer.sv
hdl/ps2mct_tracker.sv
hdl/ps2_mouse_packet_cursor_tracker_core.sv
hdl/ps2mct_checker.sv
tb/ps2mct_cursor_checker.sv
tb/tb_ps2_mouse_packet_cursor_tracker_core.sv
